[sv/bfpa_pkg.sv]
// Shared types and constants of the best-fit partition allocator.
package bfpa_pkg;

  localparam int MaxParts  = 64;
  localparam int SlotW     = $clog2(MaxParts);
  localparam int CountW    = $clog2(MaxParts + 1);
  localparam int ValW      = 21;
  localparam int UnitW     = 17;
  localparam int StatW     = 3;
  localparam int CfgIdxW   = 1;

  localparam logic [ValW-1:0]  TotalReset = 21'd1048576;
  localparam logic [UnitW-1:0] UnitReset  = 17'd4096;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_NO_FIT  = 3'd1,
    ST_FULL    = 3'd2,
    ST_BAD_IDX = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOTAL = 1'b0,
    CFG_UNIT  = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef struct packed {
    logic            kind;
    logic [ValW-1:0] request_bytes;
    logic [SlotW-1:0] partition_slot;
  } in_word_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [SlotW-1:0] granted_slot;
    logic [ValW-1:0]  granted_start;
    logic [ValW-1:0]  granted_units;
  } out_word_t;

  // Divider control and status between the top level and the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[sv/bfpa_if.sv]
// Valid/ready channel interface carrying one word of the allocator.
interface bfpa_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/bfpa_div.sv]
// Restoring radix-2 divider computing ceil(num / den), one quotient bit per cycle.
module bfpa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bfpa_pkg::div_ctl_t         ctl,
  input  logic [bfpa_pkg::ValW-1:0]  num,
  input  logic [bfpa_pkg::UnitW-1:0] den,
  output bfpa_pkg::div_sts_t         sts,
  output logic [bfpa_pkg::ValW-1:0]  quo
);
  import bfpa_pkg::*;

  localparam int StepW = $clog2(ValW + 1);

  logic [ValW-1:0]  quo_r, quo_nxt;
  logic [ValW-1:0]  num_r, num_nxt;
  logic [UnitW:0]   rem_r, rem_nxt;
  logic [UnitW-1:0] den_r, den_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [UnitW:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[UnitW-1:0], num_r[ValW-1]};
    if (ctl.start) begin
      num_nxt  = num;
      den_nxt  = (den == '0) ? UnitW'(1) : den;
      rem_nxt  = '0;
      quo_nxt  = '0;
      step_nxt = StepW'(ValW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (step_r != '0) begin
        num_nxt = {num_r[ValW-2:0], 1'b0};
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = trial - {1'b0, den_r};
          quo_nxt = {quo_r[ValW-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[ValW-2:0], 1'b0};
        end
        step_nxt = step_r - StepW'(1);
      end else begin
        // Round up when anything is left over.
        if (rem_r != '0) begin
          quo_nxt = quo_r + ValW'(1);
        end
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo      = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) $fell(busy_r) |-> done_r)
    else $error("divider ended without done");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> den_r != '0)
    else $error("divider divisor is zero");
endmodule

[sv/best_fit_partition_allocator_core.sv]
// Flow: an allocate runs the serial divider, then reads and evaluates each table entry in the
// scan (S_SCAN_RD, S_SCAN_EV) and reads and writes each moved entry in the insert shift
// (S_SHIFT_RD, S_SHIFT_WR). A free reads its entry in S_FREE_RD and S_FREE_RES before S_OUT;
// an error found at accept goes straight to S_OUT. One word is worked on at a time; the block
// is not ready meanwhile. Throughput is set by the serial divider and the table memories.
// Reset (synchronous, rst_n low) restores the default registers, then the divider computes
// the size of the single free hole before the first word is accepted.
module best_fit_partition_allocator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bfpa_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bfpa_pkg::ValW-1:0]    cfg_wdata,
  bfpa_if.sink                         in_ch,
  bfpa_if.source                       out_ch
);
  import bfpa_pkg::*;

  typedef enum logic [3:0] {
    S_INIT_GO, S_INIT_WAIT, S_IDLE, S_FREE_RD, S_FREE_RES,
    S_DIV_WAIT, S_SCAN_RD, S_SCAN_EV, S_SHIFT_RD, S_SHIFT_WR, S_SPLIT, S_OUT
  } state_t;

  // Table memories. Entry 0 is written by the init sequence; others are written before
  // they are ever read, since reads only go below the entry count.
  logic [ValW-1:0] start_mem [MaxParts];
  logic [ValW-1:0] len_mem   [MaxParts];
  logic            used_mem  [MaxParts];

  state_t           state_r, state_nxt;
  logic [ValW-1:0]  total_r, total_nxt;
  logic [UnitW-1:0] unit_r, unit_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [CountW-1:0] idx_r, idx_nxt;
  logic [SlotW-1:0] best_r, best_nxt;
  logic             found_r, found_nxt;
  logic [ValW-1:0]  best_len_r, best_len_nxt;
  logic [ValW-1:0]  units_r, units_nxt;
  logic             kind_r, kind_nxt;
  logic [SlotW-1:0] slot_r, slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  // Memory port signals.
  logic             mem_we;
  logic [SlotW-1:0] mem_waddr;
  logic [ValW-1:0]  mem_wstart, mem_wlen;
  logic [SlotW-1:0] mem_raddr;
  logic [ValW-1:0]  rd_start_r, rd_len_r;
  logic             rd_used_r;
  logic             used_we;
  logic [SlotW-1:0] used_addr;
  logic             used_val;

  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic [ValW-1:0]  div_num;
  logic [ValW-1:0]  div_quo;
  logic [SlotW-1:0] idx_s;
  logic             in_fire;

  assign idx_s   = idx_r[SlotW-1:0];
  assign in_fire = in_ch.valid && in_ch.ready;

  bfpa_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (div_ctl),
    .num  (div_num),
    .den  (unit_r),
    .sts  (div_sts),
    .quo  (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    unit_nxt      = unit_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    best_len_nxt  = best_len_r;
    units_nxt     = units_r;
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wstart    = '0;
    mem_wlen      = '0;
    mem_raddr     = idx_s;
    used_we       = 1'b0;
    used_addr     = idx_s;
    used_val      = 1'b0;
    div_ctl.start = 1'b0;
    div_num       = total_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT_GO: begin
        div_ctl.start = 1'b1;
        count_nxt     = CountW'(1);
        state_nxt     = S_INIT_WAIT;
      end
      S_INIT_WAIT: begin
        if (div_sts.done) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wstart = '0;
          mem_wlen  = div_quo;
          used_we   = 1'b1;
          used_addr = '0;
          used_val  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt = in_ch.data.kind;
          slot_nxt = in_ch.data.partition_slot;
          if (in_ch.data.kind == KIND_FREE) begin
            if ({1'b0, in_ch.data.partition_slot} >= count_r) begin
              out_nxt   = '{status: ST_BAD_IDX, default: '0};
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_FREE_RD;
            end
          end else if (in_ch.data.request_bytes == '0) begin
            out_nxt   = '{status: ST_ZERO, default: '0};
            state_nxt = S_OUT;
          end else begin
            div_ctl.start = 1'b1;
            div_num       = in_ch.data.request_bytes;
            state_nxt     = S_DIV_WAIT;
          end
        end else if (cfg_we) begin
          // A register write resets the table to one free hole.
          if (cfg_index == CFG_TOTAL) begin
            total_nxt = cfg_wdata;
          end else begin
            unit_nxt = cfg_wdata[UnitW-1:0];
          end
          state_nxt = S_INIT_GO;
        end
      end
      S_FREE_RD: begin
        mem_raddr = slot_r;
        state_nxt = S_FREE_RES;
      end
      S_FREE_RES: begin
        used_we   = 1'b1;
        used_addr = slot_r;
        used_val  = 1'b0;
        out_nxt   = '{status: ST_OK, granted_slot: slot_r,
                      granted_start: rd_start_r, granted_units: rd_len_r};
        state_nxt = S_OUT;
      end
      S_DIV_WAIT: begin
        if (div_sts.done) begin
          units_nxt = div_quo;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx_r >= count_r) begin
          if (!found_r) begin
            out_nxt   = '{status: ST_NO_FIT, default: '0};
            state_nxt = S_OUT;
          end else if (count_r >= CountW'(MaxParts)) begin
            out_nxt   = '{status: ST_FULL, default: '0};
            state_nxt = S_OUT;
          end else begin
            idx_nxt   = count_r;
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          mem_raddr = idx_s;
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        state_nxt = S_SCAN_RD;
        idx_nxt   = idx_r + CountW'(1);
        if (!rd_used_r && rd_len_r >= units_r) begin
          if (rd_len_r == units_r) begin
            used_we   = 1'b1;
            used_val  = 1'b1;
            out_nxt   = '{status: ST_OK, granted_slot: idx_s,
                          granted_start: rd_start_r, granted_units: units_r};
            state_nxt = S_OUT;
          end else if (!found_r || rd_len_r < best_len_r) begin
            found_nxt    = 1'b1;
            best_nxt     = idx_s;
            best_len_nxt = rd_len_r;
          end
        end
      end
      S_SHIFT_RD: begin
        // Move entries above the chosen hole up by one, top first.
        if (idx_r > {1'b0, best_r} + CountW'(1)) begin
          mem_raddr = idx_s - SlotW'(1);
          state_nxt = S_SHIFT_WR;
        end else begin
          mem_raddr = best_r;
          state_nxt = S_SPLIT;
        end
      end
      S_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_s;
        mem_wstart = rd_start_r;
        mem_wlen   = rd_len_r;
        used_we    = 1'b1;
        used_val   = rd_used_r;
        idx_nxt    = idx_r - CountW'(1);
        state_nxt  = S_SHIFT_RD;
      end
      S_SPLIT: begin
        // Remainder goes right after the granted front part.
        mem_we     = 1'b1;
        mem_waddr  = best_r + SlotW'(1);
        mem_wstart = rd_start_r + units_r;
        mem_wlen   = best_len_r - units_r;
        used_we    = 1'b1;
        used_addr  = best_r + SlotW'(1);
        used_val   = 1'b0;
        count_nxt  = count_r + CountW'(1);
        out_nxt    = '{status: ST_OK, granted_slot: best_r,
                       granted_start: rd_start_r, granted_units: units_r};
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = (kind_r == KIND_ALLOC && out_nxt.status == ST_OK
                           && mem_we) ? S_IDLE : S_IDLE;
        end
      end
      default: state_nxt = S_INIT_GO;
    endcase

    // A register write during the table build is kept and starts the build over.
    if (cfg_we && (state_r == S_INIT_GO || state_r == S_INIT_WAIT)) begin
      if (cfg_index == CFG_TOTAL) begin
        total_nxt = cfg_wdata;
      end else begin
        unit_nxt = cfg_wdata[UnitW-1:0];
      end
      state_nxt = S_INIT_GO;
    end
  end

  // The granted front length must be shrunk on a split; done with a second write port
  // avoided by writing the length in the output cycle.
  logic fix_len;
  assign fix_len = (state_r == S_SPLIT);
  logic fix_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT_GO;
      total_r     <= TotalReset;
      unit_r      <= UnitReset;
      count_r     <= CountW'(1);
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      fix_len_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      unit_r      <= unit_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      fix_len_r   <= fix_len;
    end
    idx_r      <= idx_nxt;
    best_r     <= best_nxt;
    best_len_r <= best_len_nxt;
    units_r    <= units_nxt;
    kind_r     <= kind_nxt;
    slot_r     <= slot_nxt;
    out_r      <= out_nxt;
  end

  // Table storage: one write and one registered read per cycle. The length shrink of a
  // split lands in the cycle after the remainder write, while the result waits.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      start_mem[mem_waddr] <= mem_wstart;
      len_mem[mem_waddr]   <= mem_wlen;
    end else if (fix_len_r) begin
      len_mem[best_r] <= units_r;
    end
    rd_start_r <= start_mem[mem_raddr];
    rd_len_r   <= len_mem[mem_raddr];
  end

  // Used marks share the read address of the table; the granted entry of a split is
  // marked in the same cycle as its length shrink.
  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_addr] <= used_val;
    end else if (fix_len_r) begin
      used_mem[best_r] <= 1'b1;
    end
    rd_used_r <= used_mem[mem_raddr];
  end

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CountW'(MaxParts))
    else $error("entry count above table size");
  assert property (@(posedge clk) disable iff (!rst_n) in_ch.ready |-> !out_valid_r)
    else $error("ready while a result is pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPLIT |=> count_r == $past(count_r) + CountW'(1))
    else $error("split did not grow the table");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |-> out_r.granted_units == '0)
    else $error("error result carries data");
endmodule
